@@ rtl/core/ppre_pkg.sv @@
// ----------------------------------------------------------------------------
// ppre_pkg - shared types and constants for the palette pixel run expander
// Operation and depth codes, pixel source kinds, and the RGB565 packing.
// ----------------------------------------------------------------------------
package ppre_pkg;

  // Store and run sizing
  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_RUN_PIXELS  = 1024;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int LEFT_W          = $clog2(MAX_RUN_PIXELS + 1);
  localparam int COLOR_W         = 24;
  localparam int WORD_W          = 16;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_PAL_WRITE = 2'd0,
    OP_HEADER    = 2'd1,
    OP_DATA      = 2'd2
  } op_t;

  // Bits-per-pixel codes of a run
  typedef enum logic [1:0] {
    DEPTH_1BPP  = 2'd0,
    DEPTH_4BPP  = 2'd1,
    DEPTH_8BPP  = 2'd2,
    DEPTH_16BPP = 2'd3
  } depth_t;

  // Where a pixel word comes from
  typedef enum logic [1:0] {
    SRC_MONO   = 2'd0,  // palette entry, low 16 bits as is
    SRC_PAL    = 2'd1,  // palette entry, truncated to 565
    SRC_DIRECT = 2'd2   // assembled 16 bpp word
  } pix_src_t;

  // Pixel request handed from the unpack stage to the color stage
  typedef struct packed {
    pix_src_t          src;
    logic              in_range;
    logic              last;
    logic [WORD_W-1:0] direct;
  } pix_req_t;

  // 24-bit RGB to RGB565, keeping the top bits of each channel
  function automatic logic [WORD_W-1:0] to565(input logic [COLOR_W-1:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

@@ rtl/core/palette_pixel_run_expander.sv @@
// A data beat's first pixel word passes the item register, the palette read and color stage
// register and the output register before it is offered. Throughput: one pixel word per
// cycle while pixel_stall is low; a data beat holds the unpack stage until all of its pixels
// (up to 8 at 1 bpp) are read through the single palette read port; other beats never hold it.
// Reset clears run state and pipeline valids; palette contents are undefined
// until written.
// ----------------------------------------------------------------------------
// palette_pixel_run_expander - packed pixel run to RGB565 words
// Unpack stage walks pixels of the held beat, palette RAM read stage, color
// format and output register.
// ----------------------------------------------------------------------------
module palette_pixel_run_expander
  import ppre_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          operation,
  input  logic [7:0]          palette_index,
  input  logic [COLOR_W-1:0]  palette_color,
  input  logic [1:0]          depth_code,
  input  logic [2:0]          first_pixel_offset,
  input  logic [9:0]          pixel_count,
  input  logic [7:0]          data_byte,
  output logic                pixel_valid,
  input  logic                pixel_stall,
  output logic [WORD_W-1:0]   pixel_word,
  output logic                run_last
);

  // item register
  logic               a_valid;
  op_t                a_op;
  logic [7:0]         a_index;
  logic [COLOR_W-1:0] a_color;
  logic [1:0]         a_depth;
  logic [2:0]         a_offset;
  logic [9:0]         a_count;
  logic [7:0]         a_byte;

  // run state
  logic [LEFT_W-1:0]  pixels_left, pixels_left_next;
  depth_t             run_depth, run_depth_next;
  logic [2:0]         bit_position, bit_position_next;
  logic [7:0]         held_low_byte, held_low_byte_next;
  logic               byte_phase, byte_phase_next;

  // color stage and output
  logic               b_valid;
  pix_req_t           b_req;
  pix_req_t           req;
  logic [COLOR_W-1:0] rdata;
  logic [WORD_W-1:0]  word;

  logic               emit_valid;
  logic               out_ready;
  logic               b_ready;
  logic               step;
  logic               last_pix;
  logic               byte_end;
  logic               a_done;
  logic               item_take;
  logic               pal_we;
  logic [7:0]         pal_addr;
  logic [LEFT_W-1:0]  count_sat;

  // handshake and stage flow
  assign out_ready  = !pixel_valid || !pixel_stall;
  assign b_ready    = !b_valid || out_ready;
  assign emit_valid = a_valid && (a_op == OP_DATA) && (pixels_left != '0) &&
                      !((run_depth == DEPTH_16BPP) && !byte_phase);
  assign step       = emit_valid && b_ready;
  assign last_pix   = (pixels_left == LEFT_W'(1));

  always_comb begin
    unique case (run_depth)
      DEPTH_1BPP: byte_end = (bit_position == 3'd7);
      DEPTH_4BPP: byte_end = bit_position[0];
      default:    byte_end = 1'b1;
    endcase
  end

  assign a_done     = a_valid && (emit_valid ? (b_ready && (last_pix || byte_end)) : 1'b1);
  assign item_stall = a_valid && !a_done;
  assign item_take  = item_valid && !item_stall;

  // item register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_take) begin
      a_valid <= 1'b1;
    end else if (a_done) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      a_op     <= op_t'(operation);
      a_index  <= palette_index;
      a_color  <= palette_color;
      a_depth  <= depth_code;
      a_offset <= first_pixel_offset;
      a_count  <= pixel_count;
      a_byte   <= data_byte;
    end
  end

  // pixel selection for the current position in the beat
  always_comb begin
    req        = '0;
    req.last   = last_pix;
    req.direct = {a_byte, held_low_byte};
    unique case (run_depth)
      DEPTH_1BPP: begin
        pal_addr = {7'd0, a_byte[3'd7 - bit_position]};
        req.src  = SRC_MONO;
      end
      DEPTH_4BPP: begin
        pal_addr = bit_position[0] ? {4'd0, a_byte[3:0]} : {4'd0, a_byte[7:4]};
        req.src  = SRC_PAL;
      end
      DEPTH_8BPP: begin
        pal_addr = a_byte;
        req.src  = SRC_PAL;
      end
      default: begin
        pal_addr = a_byte;
        req.src  = SRC_DIRECT;
      end
    endcase
    req.in_range = (32'(pal_addr) < PALETTE_ENTRIES);
  end

  // run state update
  always_comb begin
    if (32'(a_count) > MAX_RUN_PIXELS) begin
      count_sat = LEFT_W'(MAX_RUN_PIXELS);
    end else begin
      count_sat = LEFT_W'(a_count);
    end
  end

  always_comb begin
    pixels_left_next   = pixels_left;
    run_depth_next     = run_depth;
    bit_position_next  = bit_position;
    held_low_byte_next = held_low_byte;
    byte_phase_next    = byte_phase;
    if (a_valid && (a_op == OP_HEADER)) begin
      pixels_left_next   = count_sat;
      run_depth_next     = depth_t'(a_depth);
      held_low_byte_next = 8'd0;
      byte_phase_next    = 1'b0;
      unique case (depth_t'(a_depth))
        DEPTH_1BPP: bit_position_next = a_offset;
        DEPTH_4BPP: bit_position_next = {2'd0, a_offset[0]};
        default:    bit_position_next = 3'd0;
      endcase
    end else if (a_valid && (a_op == OP_DATA) && (pixels_left != '0) &&
                 (run_depth == DEPTH_16BPP) && !byte_phase) begin
      // low byte of a 16 bpp pair
      held_low_byte_next = a_byte;
      byte_phase_next    = 1'b1;
    end else if (step) begin
      pixels_left_next = pixels_left - LEFT_W'(1);
      unique case (run_depth)
        DEPTH_1BPP, DEPTH_4BPP: begin
          bit_position_next = (last_pix || byte_end) ? 3'd0 : bit_position + 3'd1;
        end
        DEPTH_16BPP: byte_phase_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left   <= '0;
      run_depth     <= DEPTH_1BPP;
      bit_position  <= 3'd0;
      held_low_byte <= 8'd0;
      byte_phase    <= 1'b0;
    end else begin
      pixels_left   <= pixels_left_next;
      run_depth     <= run_depth_next;
      bit_position  <= bit_position_next;
      held_low_byte <= held_low_byte_next;
      byte_phase    <= byte_phase_next;
    end
  end

  // palette store
  assign pal_we = a_valid && (a_op == OP_PAL_WRITE) && (32'(a_index) < PALETTE_ENTRIES);

  ppre_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (a_index[PAL_AW-1:0]),
    .wdata (a_color),
    .re    (step),
    .raddr (pal_addr[PAL_AW-1:0]),
    .rdata (rdata)
  );

  // color stage, paired with the registered palette read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      b_req <= req;
    end
  end

  always_comb begin
    unique case (b_req.src)
      SRC_MONO:   word = b_req.in_range ? rdata[WORD_W-1:0] : '0;
      SRC_PAL:    word = b_req.in_range ? to565(rdata) : '0;
      SRC_DIRECT: word = b_req.direct;
      default:    word = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (out_ready) begin
      pixel_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && b_valid) begin
      pixel_word <= word;
      run_last   <= b_req.last;
    end
  end

endmodule

@@ rtl/core/ppre_ram.sv @@
// ----------------------------------------------------------------------------
// ppre_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module ppre_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/ppre_checker.sv @@
// ----------------------------------------------------------------------------
// ppre_checker - port-level checks for the palette pixel run expander
// Watches both channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ppre_checker
  import ppre_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input logic [1:0]          operation,
  input logic                pixel_valid,
  input logic                pixel_stall,
  input logic [WORD_W-1:0]   pixel_word,
  input logic                run_last
);

  // a stalled pixel beat stays offered
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid)
    else $error("pixel beat dropped while stalled");

  // a stalled pixel beat keeps its payload
  a_pixel_stable: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> $stable(pixel_word) && $stable(run_last))
    else $error("pixel payload changed while stalled");

  // reset leaves no pending pixel and an open item side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !pixel_valid && !item_stall)
    else $error("pipeline not empty after reset");

  // an accepted non-data beat never holds off the beat after it
  a_ctrl_one_cycle: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (operation != OP_DATA) |=> !item_stall)
    else $error("control beat held the item side");

endmodule

bind palette_pixel_run_expander ppre_checker u_ppre_checker (.*);

@@ tb/palette_pixel_run_expander_test.sv @@
// ----------------------------------------------------------------------------
// palette_pixel_run_expander_test - self-checking bench for the run expander
// Drives palette writes, run headers and packed data beats with random gaps
// and output back-pressure. A scoreboard tracks palette and run state, works
// out the RGB565 pixel stream and compares every accepted pixel beat in order.
// ----------------------------------------------------------------------------
import ppre_pkg::*;

// One input beat, all fields side by side
typedef struct packed {
  logic [1:0]  op;
  logic [7:0]  index;
  logic [23:0] color;
  logic [1:0]  depth;
  logic [2:0]  offset;
  logic [9:0]  count;
  logic [7:0]  data;
} item_beat_t;

// One pixel beat as it should leave the block
typedef struct packed {
  logic        last;
  logic [15:0] word;
} pixel_beat_t;

class run_expander_scoreboard;
  logic [23:0] palette [PALETTE_ENTRIES];
  bit          loaded [PALETTE_ENTRIES];
  int          pixels_left;
  depth_t      run_depth;
  logic [2:0]  bit_pos;
  logic [7:0]  held_low;
  bit          byte_phase;
  pixel_beat_t expected_q [$];
  int          errors;

  function new();
    foreach (loaded[i]) begin
      loaded[i]  = 1'b0;
      palette[i] = '0;
    end
    pixels_left = 0;
    run_depth   = DEPTH_1BPP;
    bit_pos     = 3'd0;
    held_low    = 8'h00;
    byte_phase  = 1'b0;
    errors      = 0;
  endfunction

  // Keep the top bits of each channel
  function logic [15:0] rgb565(logic [23:0] c);
    logic [23:0] w;
    w = ((c & 24'hF80000) >> 8) | ((c & 24'h00FC00) >> 5) | ((c & 24'h0000F8) >> 3);
    return w[15:0];
  endfunction

  function void push_pixel(logic [15:0] w);
    pixel_beat_t e;
    pixels_left--;
    e.word = w;
    e.last = (pixels_left == 0);
    expected_q.push_back(e);
  endfunction

  // Update state for an accepted input beat and queue the pixels it yields
  function void note_item(item_beat_t b);
    case (b.op)
      OP_PAL_WRITE: begin
        palette[b.index] = b.color;
        loaded[b.index]  = 1'b1;
      end
      OP_HEADER: begin
        // a 10-bit count never exceeds the run limit
        pixels_left = int'(b.count);
        run_depth   = depth_t'(b.depth);
        case (run_depth)
          DEPTH_1BPP: bit_pos = b.offset;
          DEPTH_4BPP: bit_pos = {2'b00, b.offset[0]};
          default:    bit_pos = 3'd0;
        endcase
        held_low   = 8'h00;
        byte_phase = 1'b0;
      end
      OP_DATA: begin
        if (pixels_left != 0) begin
          case (run_depth)
            DEPTH_1BPP: begin
              // mono entries pass their low 16 bits as is
              for (int p = int'(bit_pos); p < 8 && pixels_left != 0; p++)
                push_pixel(palette[b.data[7-p]][15:0]);
              bit_pos = 3'd0;
            end
            DEPTH_4BPP: begin
              if (!bit_pos[0]) push_pixel(rgb565(palette[b.data[7:4]]));
              if (pixels_left != 0) push_pixel(rgb565(palette[b.data[3:0]]));
              bit_pos = 3'd0;
            end
            DEPTH_8BPP: push_pixel(rgb565(palette[b.data]));
            default: begin
              // 16 bpp: low byte first, word goes out on the high byte
              if (!byte_phase) begin
                held_low   = b.data;
                byte_phase = 1'b1;
              end else begin
                byte_phase = 1'b0;
                push_pixel({b.data, held_low});
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Compare an accepted pixel beat with the oldest expectation
  task check_pixel(logic [15:0] word, logic last);
    pixel_beat_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("pixel %h last %b with nothing expected", word, last));
      return;
    end
    e = expected_q.pop_front();
    if (word !== e.word)
      report($sformatf("pixel_word %h, expected %h", word, e.word));
    if (last !== e.last)
      report($sformatf("run_last %b, expected %b (word %h)", last, e.last, e.word));
  endtask
endclass

module palette_pixel_run_expander_test;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         RANDOM_BEATS = 270;
  localparam int         TAIL_CYCLES  = 16;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  logic [1:0]          operation;
  logic [7:0]          palette_index;
  logic [COLOR_W-1:0]  palette_color;
  logic [1:0]          depth_code;
  logic [2:0]          first_pixel_offset;
  logic [9:0]          pixel_count;
  logic [7:0]          data_byte;
  logic                pixel_valid;
  logic                pixel_stall;
  logic [WORD_W-1:0]   pixel_word;
  logic                run_last;

  run_expander_scoreboard sb;
  int hold_request = 0;
  int live_beats   = 0;
  int sender_draws = 0;
  int cycle_count;

  palette_pixel_run_expander dut (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Wait before a beat: quiet stretches with no gaps, else a random gap
  function automatic int draw_wait(int seq);
    if ((seq / 40) % 3 == 1) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Random entry already loaded, below lim; entries 0 and 1 are loaded first
  function automatic logic [7:0] pick_entry(int lim);
    int k;
    for (int t = 0; t < 16; t++) begin
      k = $urandom_range(0, lim - 1);
      if (sb.loaded[k]) return k[7:0];
    end
    k = $urandom_range(0, 1);
    return k[7:0];
  endfunction

  // Data byte that only reads loaded palette entries
  function automatic logic [7:0] pick_data();
    logic [7:0] hi;
    logic [7:0] lo;
    logic [31:0] r;
    r = $urandom;
    if (sb.pixels_left == 0 || sb.run_depth == DEPTH_1BPP || sb.run_depth == DEPTH_16BPP)
      return r[7:0];
    if (sb.run_depth == DEPTH_4BPP) begin
      hi = pick_entry(16);
      lo = pick_entry(16);
      return {hi[3:0], lo[3:0]};
    end
    return pick_entry(PALETTE_ENTRIES);
  endfunction

  // Beat with random content in every field
  function automatic item_beat_t noise_beat(logic [1:0] op);
    item_beat_t b;
    logic [31:0] r0;
    logic [31:0] r1;
    r0 = $urandom;
    r1 = $urandom;
    b.op     = op;
    b.index  = r0[7:0];
    b.color  = r0[31:8];
    b.depth  = r1[1:0];
    b.offset = r1[4:2];
    b.count  = r1[14:5];
    b.data   = r1[22:15];
    return b;
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input item_beat_t b);
    int gap;
    gap = draw_wait(sender_draws);
    sender_draws++;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid         <= 1'b1;
    operation          <= b.op;
    palette_index      <= b.index;
    palette_color      <= b.color;
    depth_code         <= b.depth;
    first_pixel_offset <= b.offset;
    pixel_count        <= b.count;
    data_byte          <= b.data;
    do @(posedge clk); while (item_stall);
    if (b.op == OP_PAL_WRITE || b.op == OP_HEADER || (b.op == OP_DATA && sb.pixels_left != 0))
      live_beats++;
    sb.note_item(b);
    @(negedge clk);
  endtask

  task automatic write_entry(int idx, int color);
    item_beat_t b;
    b = noise_beat(OP_PAL_WRITE);
    b.index = idx[7:0];
    b.color = color[23:0];
    send_beat(b);
  endtask

  task automatic start_run(int depth, int offs, int count);
    item_beat_t b;
    b = noise_beat(OP_HEADER);
    b.depth  = depth[1:0];
    b.offset = offs[2:0];
    b.count  = count[9:0];
    send_beat(b);
  endtask

  task automatic send_byte(logic [7:0] d);
    item_beat_t b;
    b = noise_beat(OP_DATA);
    b.data = d;
    send_beat(b);
  endtask

  // Sender pause: idle until every queued pixel has come out
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_q.size() != 0);
  endtask

  // Pixel receiver: random stall after each beat, plus a long hold on request
  initial begin : pixel_sink
    int wait_left;
    int draws;
    wait_left   = 0;
    draws       = 0;
    pixel_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        wait_left    = hold_request;
        hold_request = 0;
      end else if (wait_left == 0 && !rst && pixel_valid && !pixel_stall) begin
        wait_left = draw_wait(draws);
        draws++;
      end
      @(negedge clk);
      if (wait_left != 0) begin
        pixel_stall <= 1'b1;
        wait_left--;
      end else begin
        pixel_stall <= 1'b0;
      end
    end
  end

  // Check every accepted pixel beat
  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) sb.check_pixel(pixel_word, run_last);
  end

  // Run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int roll;
    int count;
    sb                 = new();
    rst                = 1'b1;
    item_valid         = 1'b0;
    operation          = 2'd0;
    palette_index      = 8'h00;
    palette_color      = '0;
    depth_code         = 2'd0;
    first_pixel_offset = 3'd0;
    pixel_count        = 10'd0;
    data_byte          = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: mono colors first, then one short run per depth and run edge cases
    write_entry(0, 24'h00F81F);
    write_entry(1, 24'hFF07E0);
    write_entry(15, 24'hFFFFFF);
    write_entry(170, 24'h000000);
    write_entry(255, 24'h5A3C96);
    send_beat(noise_beat(OP_UNUSED));
    // 1 bpp starting at sub-pixel 5, run spans two bytes
    start_run(DEPTH_1BPP, 5, 11);
    send_byte(8'hA5);
    send_byte(8'h3C);
    // 4 bpp with odd offset skips the first high nibble
    start_run(DEPTH_4BPP, 1, 3);
    send_byte(8'hF0);
    send_byte(8'h0F);
    // 8 bpp ignores the offset
    start_run(DEPTH_8BPP, 7, 2);
    send_byte(8'hFF);
    send_byte(8'hAA);
    // 16 bpp pairs, low byte first
    start_run(DEPTH_16BPP, 0, 2);
    send_byte(8'h34);
    send_byte(8'h12);
    send_byte(8'hFF);
    send_byte(8'h00);
    // longest run, abandoned by a new header
    start_run(DEPTH_1BPP, 0, 1023);
    send_byte(8'h81);
    // header drops a held low byte; zero count ends the run
    start_run(DEPTH_16BPP, 3, 4);
    send_byte(8'h77);
    start_run(DEPTH_8BPP, 0, 0);
    send_byte(8'h55);
    wait_drained();

    // Long output hold while a full 1 bpp run is offered
    hold_request = HOLD_CYCLES;
    start_run(DEPTH_1BPP, 0, 64);
    repeat (8) send_byte(pick_data());

    // Random: mostly well-formed runs, some noise and broken runs
    live_beats = 0;
    while (live_beats < RANDOM_BEATS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        count = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        start_run($urandom_range(0, 3), $urandom_range(0, 7), count);
        while (sb.pixels_left != 0 && $urandom_range(0, 39) != 0) begin
          if ($urandom_range(0, 14) == 0) write_entry($urandom_range(0, 255), $urandom);
          send_byte(pick_data());
        end
        if ($urandom_range(0, 7) == 0) send_byte(pick_data());
      end else if (roll < 82) begin
        write_entry($urandom_range(0, 255), $urandom);
      end else if (roll < 88) begin
        send_beat(noise_beat(OP_UNUSED));
      end else if (roll < 94) begin
        send_byte(pick_data());
      end else begin
        count = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 1023);
        start_run($urandom_range(0, 3), $urandom_range(0, 7), count);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
